@@ sv/dasu_pkg.sv @@
`default_nettype none

package dasu_pkg;

    localparam int FRAC_BITS = 16;

    localparam int STEP_W   = 16;
    localparam int LEVEL_W  = 17;
    localparam int COUNT_W  = 8;
    localparam int ALERT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int IN_DATA_W = 24;
    localparam int IN_USER_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_POSE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [ALERT_W-1:0] ALERT_NONE     = 2'd0;
    localparam logic [ALERT_W-1:0] ALERT_PRE      = 2'd1;
    localparam logic [ALERT_W-1:0] ALERT_PROMPT   = 2'd2;
    localparam logic [ALERT_W-1:0] ALERT_TERMINAL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STEP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSIVE_STEP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PRE_LEVEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PROMPT_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSIVE_PRE_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSIVE_PROMPT_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTENTIVE_LIMIT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTRACTED_LIMIT     = 3'd7;

    localparam logic [STEP_W-1:0]  RST_ACTIVE_STEP          = 16'd60;
    localparam logic [STEP_W-1:0]  RST_PASSIVE_STEP         = 16'd7;
    localparam logic [LEVEL_W-1:0] RST_ACTIVE_PRE_LEVEL     = 17'd47662;
    localparam logic [LEVEL_W-1:0] RST_ACTIVE_PROMPT_LEVEL  = 17'd35747;
    localparam logic [LEVEL_W-1:0] RST_PASSIVE_PRE_LEVEL    = 17'd16384;
    localparam logic [LEVEL_W-1:0] RST_PASSIVE_PROMPT_LEVEL = 17'd9830;
    localparam logic [LEVEL_W-1:0] RST_ATTENTIVE_LIMIT      = 17'd24248;
    localparam logic [LEVEL_W-1:0] RST_DISTRACTED_LIMIT     = 17'd41288;

    typedef enum logic [1:0] {
        STEP_ACTIVE  = 2'd0,
        STEP_PASSIVE = 2'd1,
        STEP_ZERO    = 2'd2
    } t_step;

    typedef struct packed {
        logic [STEP_W-1:0]  active_step;
        logic [STEP_W-1:0]  passive_step;
        logic [LEVEL_W-1:0] active_pre_level;
        logic [LEVEL_W-1:0] active_prompt_level;
        logic [LEVEL_W-1:0] passive_pre_level;
        logic [LEVEL_W-1:0] passive_prompt_level;
        logic [LEVEL_W-1:0] attentive_limit;
        logic [LEVEL_W-1:0] distracted_limit;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic               face_seen;
        logic               looking_away;
        logic [LEVEL_W-1:0] distraction_level;
        logic               hands_on;
        logic               control_on;
        logic               standstill;
    } t_item;

endpackage

`default_nettype wire

@@ sv/dasu_cfg.sv @@
`default_nettype none

module dasu_cfg
    import dasu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_step          <= RST_ACTIVE_STEP;
            r_cfg.passive_step         <= RST_PASSIVE_STEP;
            r_cfg.active_pre_level     <= RST_ACTIVE_PRE_LEVEL;
            r_cfg.active_prompt_level  <= RST_ACTIVE_PROMPT_LEVEL;
            r_cfg.passive_pre_level    <= RST_PASSIVE_PRE_LEVEL;
            r_cfg.passive_prompt_level <= RST_PASSIVE_PROMPT_LEVEL;
            r_cfg.attentive_limit      <= RST_ATTENTIVE_LIMIT;
            r_cfg.distracted_limit     <= RST_DISTRACTED_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_STEP:          r_cfg.active_step <= i_cfg_data[STEP_W-1:0];
                CFG_PASSIVE_STEP:         r_cfg.passive_step <= i_cfg_data[STEP_W-1:0];
                CFG_ACTIVE_PRE_LEVEL:     r_cfg.active_pre_level <= i_cfg_data;
                CFG_ACTIVE_PROMPT_LEVEL:  r_cfg.active_prompt_level <= i_cfg_data;
                CFG_PASSIVE_PRE_LEVEL:    r_cfg.passive_pre_level <= i_cfg_data;
                CFG_PASSIVE_PROMPT_LEVEL: r_cfg.passive_prompt_level <= i_cfg_data;
                CFG_ATTENTIVE_LIMIT:      r_cfg.attentive_limit <= i_cfg_data;
                CFG_DISTRACTED_LIMIT:     r_cfg.distracted_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/dasu_core.sv @@
`default_nettype none

module dasu_core
    import dasu_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire t_item                       i_item,
    input  wire t_cfg                        i_cfg,
    output logic [ALERT_W-1:0]               o_alert_level,
    output logic                             o_passive_mode,
    output logic signed [FRAC_BITS+1:0]      o_awareness_now,
    output logic [COUNT_W-1:0]               o_terminal_count
);

    localparam int AW = FRAC_BITS + 2;
    localparam int WW = FRAC_BITS + 24;
    localparam int FW = FRAC_BITS + 5;
    localparam int PW = FW + STEP_W;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic signed [WW-1:0] ONE_W   = WW'(ONE_L);
    localparam logic signed [WW-1:0] FLOOR_W = WW'(-((ONE_L + 5) / 10));
    localparam logic signed [AW-1:0] ONE_A   = AW'(ONE_L);

    logic signed [AW-1:0] r_aw, n_aw;
    logic signed [AW-1:0] r_sa, n_sa;
    logic signed [AW-1:0] r_sp, n_sp;
    logic                 r_passive, n_passive;
    t_step                r_step, n_step;
    logic                 r_face, n_face;
    logic                 r_dist, n_dist;
    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [COUNT_W-1:0]   r_tcnt, n_tcnt;

    logic signed [WW-1:0] aw_w, sp_w, step_w, prompt_w, pre_w, act_prompt_w;
    logic signed [WW-1:0] diff_w, inc_w, a_w, spn_w;
    logic [FW-1:0]        fac;
    logic [PW-1:0]        prod;
    logic                 done;
    logic [ALERT_W-1:0]   alert;

    always_comb begin
        aw_w = WW'(r_aw);
        sp_w = WW'(r_sp);
        case (r_step)
            STEP_ACTIVE:  step_w = WW'(i_cfg.active_step);
            STEP_PASSIVE: step_w = WW'(i_cfg.passive_step);
            default:      step_w = '0;
        endcase
        prompt_w = r_passive ? WW'(i_cfg.passive_prompt_level)
                             : WW'(i_cfg.active_prompt_level);
        pre_w    = r_passive ? WW'(i_cfg.passive_pre_level)
                             : WW'(i_cfg.active_pre_level);
        act_prompt_w = WW'(i_cfg.active_prompt_level);

        diff_w = ONE_W - aw_w;
        fac    = FW'(diff_w * 15 + ONE_W * 5);
        prod   = PW'(fac) * PW'(step_w[STEP_W-1:0]);
        inc_w  = WW'(prod >> (FRAC_BITS + 2));

        n_aw      = r_aw;
        n_sa      = r_sa;
        n_sp      = r_sp;
        n_passive = r_passive;
        n_step    = r_step;
        n_face    = r_face;
        n_dist    = r_dist;
        n_level   = r_level;
        n_tcnt    = r_tcnt;
        alert     = ALERT_NONE;
        a_w       = aw_w;
        spn_w     = sp_w;
        done      = 1'b0;

        if (i_item.op == OP_POSE) begin
            n_face  = i_item.face_seen;
            n_dist  = i_item.looking_away;
            n_level = i_item.distraction_level;
            if (!r_passive && aw_w <= act_prompt_w) begin
                n_step = i_item.face_seen ? STEP_ACTIVE : STEP_ZERO;
            end else if (aw_w > 0) begin
                if (i_item.face_seen) begin
                    if (r_passive) begin
                        n_sp = r_aw;
                        n_aw = r_sa;
                    end
                    n_passive = 1'b0;
                    n_step    = STEP_ACTIVE;
                end else begin
                    if (!r_passive) begin
                        n_sa = r_aw;
                        n_aw = r_sp;
                    end
                    n_passive = 1'b1;
                    n_step    = STEP_PASSIVE;
                end
            end
        end else if ((i_item.hands_on && aw_w > 0) || !i_item.control_on) begin
            n_aw = ONE_A;
            n_sa = ONE_A;
            n_sp = ONE_A;
        end else begin
            if (r_level < i_cfg.attentive_limit && r_face && aw_w > 0) begin
                a_w = aw_w + inc_w;
                if (a_w > ONE_W) begin
                    a_w = ONE_W;
                end
                if (a_w == ONE_W) begin
                    spn_w = sp_w + step_w;
                    if (spn_w > ONE_W) begin
                        spn_w = ONE_W;
                    end
                end
                if (a_w > prompt_w) begin
                    done = 1'b1;
                end
            end
            if (!done) begin
                if ((!r_face || (WW'(r_level) > WW'(i_cfg.distracted_limit) && r_dist))
                    && !(i_item.standstill && (a_w - step_w) <= prompt_w)) begin
                    a_w = a_w - step_w;
                    if (a_w < FLOOR_W) begin
                        a_w = FLOOR_W;
                    end
                end
                if (a_w <= 0) begin
                    alert = ALERT_TERMINAL;
                    if (aw_w > 0 && r_tcnt != COUNT_MAX) begin
                        n_tcnt = r_tcnt + COUNT_W'(1);
                    end
                end else if (a_w <= prompt_w) begin
                    alert = ALERT_PROMPT;
                end else if (a_w <= pre_w) begin
                    alert = ALERT_PRE;
                end
            end
            n_aw = AW'(a_w);
            n_sp = AW'(spn_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw      <= ONE_A;
            r_sa      <= ONE_A;
            r_sp      <= ONE_A;
            r_passive <= 1'b0;
            r_step    <= STEP_ACTIVE;
            r_face    <= 1'b0;
            r_dist    <= 1'b0;
            r_level   <= '0;
            r_tcnt    <= '0;
        end else if (i_en) begin
            r_aw      <= n_aw;
            r_sa      <= n_sa;
            r_sp      <= n_sp;
            r_passive <= n_passive;
            r_step    <= n_step;
            r_face    <= n_face;
            r_dist    <= n_dist;
            r_level   <= n_level;
            r_tcnt    <= n_tcnt;
        end
    end

    assign o_alert_level    = alert;
    assign o_passive_mode   = n_passive;
    assign o_awareness_now  = n_aw;
    assign o_terminal_count = n_tcnt;

endmodule

`default_nettype wire

@@ sv/driver_awareness_supervisor_unit.sv @@
`default_nettype none

// Driver awareness supervisor. Each input word is either a pose report
// (tuser 0) or a control tick (tuser 1), and each yields exactly one output
// word with the alert level, the mode, the current awareness and the
// saturating terminal-alert count. A word goes through an input register,
// combinational update logic against the state registers, and an output
// register, and one word is taken in every cycle unless the output stalls;
// the recovery multiplier of step by shortfall sets the clock period.
// Configuration writes apply from the next cycle and belong in idle periods.

module driver_awareness_supervisor_unit
    import dasu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // face_seen, looking_away, distraction_level[16:0],
    // hands_on, control_on, standstill, zero fill
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // op
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // alert_level[1:0], passive_mode, awareness_now[FRAC_BITS+1:0],
    // terminal_count[7:0], zero fill
    output logic [((FRAC_BITS + 2 + ALERT_W + 1 + COUNT_W + 7) / 8) * 8 - 1:0]
                                       o_m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = FRAC_BITS + 2;
    localparam int RES_W = ALERT_W + 1 + AW + COUNT_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    t_cfg                    cfg;
    t_item                   item;
    logic                    r_in_valid;
    t_item                   r_item;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;
    logic                    advance;
    logic [ALERT_W-1:0]      alert_level;
    logic                    passive_mode;
    logic signed [AW-1:0]    awareness_now;
    logic [COUNT_W-1:0]      terminal_count;

    assign item.op                = i_s_axis_tuser[0];
    assign item.face_seen         = i_s_axis_tdata[0];
    assign item.looking_away      = i_s_axis_tdata[1];
    assign item.distraction_level = i_s_axis_tdata[LEVEL_W+1:2];
    assign item.hands_on          = i_s_axis_tdata[LEVEL_W+2];
    assign item.control_on        = i_s_axis_tdata[LEVEL_W+3];
    assign item.standstill        = i_s_axis_tdata[LEVEL_W+4];

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    dasu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dasu_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (advance),
        .i_item           (r_item),
        .i_cfg            (cfg),
        .o_alert_level    (alert_level),
        .o_passive_mode   (passive_mode),
        .o_awareness_now  (awareness_now),
        .o_terminal_count (terminal_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item <= item;
        end
        if (advance) begin
            r_out_data <= OUT_W'({terminal_count, awareness_now, passive_mode, alert_level});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
